// File: rtl/plen_pkg.sv
package plen_pkg;

  localparam int DEFAULT_CAPACITY = 128;

  localparam int ACTION_W = 4;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE  = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_READ    = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_LOCATE  = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_PRED    = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_SUCC    = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_MAXIMUM = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SORT    = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_REVERSE = 4'd9;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // what every cell does, as broadcast by the sequencer
  typedef enum logic [2:0] {
    M_HOLD  = 3'd0,
    M_INS   = 3'd1,
    M_DEL   = 3'd2,
    M_ROT   = 3'd3,
    M_TAG   = 3'd4,
    M_CSWAP = 3'd5
  } plen_mode_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_SORT = 5'b01000,
    S_DONE = 5'b10000
  } plen_state_e;

  // broadcast control from the sequencer to the row of cells
  typedef struct packed {
    plen_mode_e         mode;
    logic [POS_W-1:0]   pos0;
    logic               phase;
    logic               by_tag;
    logic [VALUE_W-1:0] value;
  } plen_ctrl_t;

endpackage

// File: rtl/plen_in_if.sv
interface plen_in_if;
  logic                                valid;
  logic                                ready;
  logic [plen_pkg::ACTION_W-1:0]       action;
  logic [plen_pkg::POS_W-1:0]          position;
  logic signed [plen_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

// File: rtl/plen_out_if.sv
interface plen_out_if;
  logic                                valid;
  logic                                ready;
  logic [plen_pkg::STATUS_W-1:0]       status;
  logic signed [plen_pkg::VALUE_W-1:0] found_value;
  logic [plen_pkg::INDEX_W-1:0]        found_index;
  logic [plen_pkg::INDEX_W-1:0]        list_count;
  logic                                is_empty;

  modport source (output valid, status, found_value, found_index, list_count, is_empty,
                  input ready);
  modport sink (input valid, status, found_value, found_index, list_count, is_empty,
                output ready);
endinterface

// File: rtl/plen_cell.sv
module plen_cell #(
  parameter int CAPACITY = plen_pkg::DEFAULT_CAPACITY,
  parameter int IDX      = 0,
  localparam int IW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  plen_pkg::plen_ctrl_t          ctrl_i,
  input  logic [CW-1:0]                 count_i,
  input  logic [plen_pkg::VALUE_W-1:0]  left_val_i,
  input  logic [IW-1:0]                 left_tag_i,
  input  logic [plen_pkg::VALUE_W-1:0]  right_val_i,
  input  logic [IW-1:0]                 right_tag_i,
  output logic [plen_pkg::VALUE_W-1:0]  val_o,
  output logic [IW-1:0]                 tag_o
);

  logic [plen_pkg::VALUE_W-1:0] val_q, val_d;
  logic [IW-1:0]                tag_q, tag_d;
  logic                         is_left, is_right, gt_right, gt_left;

  // pair membership for the current transposition phase
  assign is_left  = ((IDX % 2) == int'(ctrl_i.phase)) && (IDX + 1 < int'(count_i));
  assign is_right = (IDX >= 1) && (((IDX + 1) % 2) == int'(ctrl_i.phase))
                    && (IDX < int'(count_i));

  // order compare on value or on reversal tag
  assign gt_right = ctrl_i.by_tag ? (tag_q > right_tag_i)
                                  : ($signed(val_q) > $signed(right_val_i));
  assign gt_left  = ctrl_i.by_tag ? (left_tag_i > tag_q)
                                  : ($signed(left_val_i) > $signed(val_q));

  // next entry
  always_comb begin
    val_d = val_q;
    tag_d = tag_q;
    case (ctrl_i.mode)
      plen_pkg::M_INS: begin
        if (IDX > int'(ctrl_i.pos0)) val_d = left_val_i;
        else if (IDX == int'(ctrl_i.pos0)) val_d = ctrl_i.value;
      end
      plen_pkg::M_DEL: begin
        if (IDX >= int'(ctrl_i.pos0)) val_d = right_val_i;
      end
      plen_pkg::M_ROT: begin
        val_d = right_val_i;
      end
      plen_pkg::M_TAG: begin
        tag_d = IW'(int'(count_i) - 1 - IDX);
      end
      plen_pkg::M_CSWAP: begin
        if (is_left && gt_right) begin
          val_d = right_val_i;
          tag_d = right_tag_i;
        end else if (is_right && gt_left) begin
          val_d = left_val_i;
          tag_d = left_tag_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    tag_q <= tag_d;
  end

  assign val_o = val_q;
  assign tag_o = tag_q;

endmodule

// File: rtl/positional_list_engine_unit.sv
// positional list engine: an ordered list of up to CAPACITY signed words
// input channel in_i carries one item (action, position, value); output
// channel out_o returns exactly one result item per input item
// the list lives in a ring of cells; each cell holds one entry and trades
// with its neighbors as the mode broadcast by the sequencer directs
// clear, insert, delete and bad-position items: done in the exec state
// read, locate, predecessor, successor, maximum: the result is set
//   by one full rotation of the ring past the head cell
// sort and reverse (after loading descending tags): set by CAPACITY
//   rounds of odd-even transposition between neighbor cells
// one item is worked on at a time; the next is accepted once the previous
// result sits in the output register, so a stalled receiver holds one
// result while the next item is taken and worked on
// reset empties the list at once (count to zero); entry contents are not
// cleared and are never read before being written
// a result waits in the sequencer until the output register is free
module positional_list_engine_unit #(
  parameter int CAPACITY = plen_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plen_in_if.sink     in_i,
  plen_out_if.source  out_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  plen_pkg::plen_state_e state_q, state_d;

  logic [plen_pkg::ACTION_W-1:0] act_q;
  logic [plen_pkg::POS_W-1:0]    pos_q;
  logic [plen_pkg::VALUE_W-1:0]  val_q;
  logic [CW-1:0]                 count_q, count_d;
  logic [IW-1:0]                 i_q, i_d;
  logic                          tag_done_q, tag_done_d;

  logic [plen_pkg::STATUS_W-1:0] r_status_q, r_status_d;
  logic [plen_pkg::VALUE_W-1:0]  r_fval_q, r_fval_d;
  logic [plen_pkg::INDEX_W-1:0]  r_fidx_q, r_fidx_d;
  logic                          r_ok_q, r_ok_d;
  logic                          hit_q, hit_d, just_q, just_d;
  logic [plen_pkg::VALUE_W-1:0]  prev_q;

  logic                          out_valid_q;
  logic [plen_pkg::STATUS_W-1:0] out_status_q;
  logic [plen_pkg::VALUE_W-1:0]  out_fval_q;
  logic [plen_pkg::INDEX_W-1:0]  out_fidx_q;
  logic [plen_pkg::INDEX_W-1:0]  out_count_q;
  logic                          out_empty_q;

  plen_pkg::plen_ctrl_t          ctrl;
  logic [plen_pkg::VALUE_W-1:0]  cell_val [CAPACITY];
  logic [IW-1:0]                 cell_tag [CAPACITY];
  logic [plen_pkg::VALUE_W-1:0]  head;
  logic                          in_range, match, out_free, accept;

  assign head     = cell_val[0];
  assign in_range = CW'(i_q) < count_q;
  assign match    = (head == val_q) && !hit_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == plen_pkg::S_IDLE);
  assign accept   = in_i.valid && in_i.ready;

  // row of cells, closed into a ring
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plen_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_val_i  (cell_val[(g + CAPACITY - 1) % CAPACITY]),
      .left_tag_i  (cell_tag[(g + CAPACITY - 1) % CAPACITY]),
      .right_val_i (cell_val[(g + 1) % CAPACITY]),
      .right_tag_i (cell_tag[(g + 1) % CAPACITY]),
      .val_o       (cell_val[g]),
      .tag_o       (cell_tag[g])
    );
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    i_d        = i_q;
    tag_done_d = tag_done_q;
    r_status_d = r_status_q;
    r_fval_d   = r_fval_q;
    r_fidx_d   = r_fidx_q;
    r_ok_d     = r_ok_q;
    hit_d      = hit_q;
    just_d     = just_q;
    ctrl.mode   = plen_pkg::M_HOLD;
    ctrl.pos0   = pos_q - 8'd1;
    ctrl.phase  = i_q[0];
    ctrl.by_tag = (act_q == plen_pkg::ACT_REVERSE);
    ctrl.value  = val_q;
    case (state_q)
      plen_pkg::S_IDLE: begin
        if (accept) state_d = plen_pkg::S_EXEC;
      end
      plen_pkg::S_EXEC: begin
        r_status_d = plen_pkg::ST_OK;
        r_fval_d   = '0;
        r_fidx_d   = '0;
        r_ok_d     = 1'b0;
        hit_d      = 1'b0;
        just_d     = 1'b0;
        i_d        = '0;
        tag_done_d = 1'b0;
        state_d    = plen_pkg::S_DONE;
        case (act_q)
          plen_pkg::ACT_CLEAR: begin
            count_d = '0;
          end
          plen_pkg::ACT_INSERT: begin
            if (pos_q == 8'd0 || int'(pos_q) > int'(count_q) + 1) begin
              r_status_d = plen_pkg::ST_BAD_POS;
            end else if (int'(count_q) >= CAPACITY) begin
              r_status_d = plen_pkg::ST_FULL;
            end else begin
              ctrl.mode = plen_pkg::M_INS;
              count_d   = count_q + CW'(1);
            end
          end
          plen_pkg::ACT_DELETE: begin
            if (pos_q == 8'd0 || int'(pos_q) > int'(count_q)) begin
              r_status_d = plen_pkg::ST_BAD_POS;
            end else begin
              ctrl.mode = plen_pkg::M_DEL;
              count_d   = count_q - CW'(1);
            end
          end
          plen_pkg::ACT_READ: begin
            if (pos_q == 8'd0 || int'(pos_q) > int'(count_q)) begin
              r_status_d = plen_pkg::ST_BAD_POS;
            end else begin
              state_d = plen_pkg::S_SCAN;
            end
          end
          plen_pkg::ACT_LOCATE, plen_pkg::ACT_PRED, plen_pkg::ACT_SUCC,
          plen_pkg::ACT_MAXIMUM: begin
            state_d = plen_pkg::S_SCAN;
          end
          plen_pkg::ACT_SORT, plen_pkg::ACT_REVERSE: begin
            state_d = plen_pkg::S_SORT;
          end
          default: begin
            state_d = plen_pkg::S_DONE;
          end
        endcase
      end
      plen_pkg::S_SCAN: begin
        // one rotation brings every entry past the head cell in order
        ctrl.mode = plen_pkg::M_ROT;
        if (in_range) begin
          case (act_q)
            plen_pkg::ACT_READ: begin
              if (int'(i_q) == int'(pos_q) - 1) begin
                r_fval_d = head;
                r_ok_d   = 1'b1;
              end
            end
            plen_pkg::ACT_LOCATE: begin
              if (match) begin
                r_fidx_d = plen_pkg::INDEX_W'(int'(i_q) + 1);
                r_ok_d   = 1'b1;
              end
            end
            plen_pkg::ACT_PRED: begin
              if (match && i_q != '0) begin
                r_fval_d = prev_q;
                r_ok_d   = 1'b1;
              end
            end
            plen_pkg::ACT_SUCC: begin
              if (just_q) begin
                r_fval_d = head;
                r_ok_d   = 1'b1;
              end
            end
            plen_pkg::ACT_MAXIMUM: begin
              if (i_q == '0 || $signed(r_fval_q) < $signed(head)) begin
                r_fval_d = head;
                r_fidx_d = plen_pkg::INDEX_W'(int'(i_q) + 1);
                r_ok_d   = 1'b1;
              end
            end
            default: begin
              r_ok_d = r_ok_q;
            end
          endcase
          hit_d  = hit_q || match;
          just_d = match;
        end else begin
          just_d = 1'b0;
        end
        i_d = i_q + IW'(1);
        if (i_q == LAST) begin
          state_d    = plen_pkg::S_DONE;
          r_status_d = r_ok_d ? plen_pkg::ST_OK : plen_pkg::ST_NOT_FOUND;
        end
      end
      plen_pkg::S_SORT: begin
        // reverse first loads descending tags, then both sort on neighbors
        if (act_q == plen_pkg::ACT_REVERSE && !tag_done_q) begin
          ctrl.mode  = plen_pkg::M_TAG;
          tag_done_d = 1'b1;
        end else begin
          ctrl.mode = plen_pkg::M_CSWAP;
          i_d       = i_q + IW'(1);
          if (i_q == LAST) state_d = plen_pkg::S_DONE;
        end
      end
      plen_pkg::S_DONE: begin
        if (out_free) state_d = plen_pkg::S_IDLE;
      end
      default: begin
        state_d = plen_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plen_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == plen_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_i.action;
      pos_q <= in_i.position;
      val_q <= in_i.value;
    end
    i_q        <= i_d;
    tag_done_q <= tag_done_d;
    r_status_q <= r_status_d;
    r_fval_q   <= r_fval_d;
    r_fidx_q   <= r_fidx_d;
    r_ok_q     <= r_ok_d;
    hit_q      <= hit_d;
    just_q     <= just_d;
    prev_q     <= head;
    if (state_q == plen_pkg::S_DONE && out_free) begin
      out_status_q <= r_status_q;
      out_fval_q   <= (r_status_q == plen_pkg::ST_OK) ? r_fval_q : '0;
      out_fidx_q   <= (r_status_q == plen_pkg::ST_OK) ? r_fidx_q : '0;
      out_count_q  <= plen_pkg::INDEX_W'(count_q);
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found_value = out_fval_q;
  assign out_o.found_index = out_fidx_q;
  assign out_o.list_count  = out_count_q;
  assign out_o.is_empty    = out_empty_q;

  // checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= CAPACITY)
    else $error("list count above capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == plen_pkg::S_EXEC)
    else $error("accepted item not executed");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plen_pkg::S_SCAN && i_q == LAST) |=> state_q == plen_pkg::S_DONE)
    else $error("scan did not finish after one rotation");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plen_pkg::S_SCAN || state_q == plen_pkg::S_SORT) |=> $stable(count_q))
    else $error("count changed during scan or sort");

endmodule
